// ===== rtl/wdg_pkg.sv =====
// ----------------------------------------------------------------------------
// wdg_pkg: shared types and constants for the multi-channel watchdog
// Channel count, counter width, operation and status codes, and the result
// record passed from the controller to the output stage.
// ----------------------------------------------------------------------------
package wdg_pkg;

    localparam int CHANNELS    = 8;
    localparam int COUNT_WIDTH = 17;
    localparam int TIMEOUT_W   = 16;
    localparam int MASK_W      = 8;
    localparam int CH_FIELD_W  = 4;
    localparam int CH_IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CMP_W       = (COUNT_WIDTH > TIMEOUT_W) ? COUNT_WIDTH : TIMEOUT_W;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = TIMEOUT_W'(60);

    typedef logic [COUNT_WIDTH-1:0] count_t;
    typedef logic [CH_IDX_W-1:0]    ch_idx_t;
    typedef logic [TIMEOUT_W-1:0]   timeout_t;
    typedef logic [MASK_W-1:0]      mask_t;

    typedef enum logic [1:0] {
        OP_TICK      = 2'd0,
        OP_ENABLE    = 2'd1,
        OP_DISABLE   = 2'd2,
        OP_KEEPALIVE = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_NOT_STARTED = 2'd1,
        ST_BAD_CHANNEL = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_SCAN = 2'd1,
        S_DONE = 2'd2
    } state_t;

    typedef struct packed {
        status_t status;
        mask_t   expired_mask;
    } result_t;

endpackage

// ===== rtl/wdg_tick_unit.sv =====
// ----------------------------------------------------------------------------
// wdg_tick_unit: shared saturating increment and timeout compare
// Applied to one channel counter per cycle during a tick scan.
// ----------------------------------------------------------------------------
module wdg_tick_unit (
    input  wdg_pkg::count_t   count_in,
    input  wdg_pkg::timeout_t timeout,
    output wdg_pkg::count_t   count_out,
    output logic              expired
);
    import wdg_pkg::*;

    logic [CMP_W-1:0] count_ext;
    logic [CMP_W-1:0] timeout_ext;

    // counter sticks at all ones
    assign count_out   = (&count_in) ? count_in : count_in + COUNT_WIDTH'(1);
    assign count_ext   = CMP_W'(count_out);
    assign timeout_ext = CMP_W'(timeout);
    assign expired     = count_ext > timeout_ext;

endmodule

// ===== rtl/wdg_ctrl.sv =====
// ----------------------------------------------------------------------------
// wdg_ctrl: sequencer and channel state for the watchdog
// Holds armed flags and seconds counters; applies channel operations in one
// step and walks all channels through the shared tick unit on a tick.
// ----------------------------------------------------------------------------
module wdg_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  wdg_pkg::op_t      op,
    input  logic [3:0]        ch,
    input  wdg_pkg::timeout_t timeout,
    output logic              res_valid,
    input  logic              res_ready,
    output wdg_pkg::result_t  result
);
    import wdg_pkg::*;

    localparam ch_idx_t LAST_IDX = CH_IDX_W'(CHANNELS - 1);

    state_t  state_reg, state_next;
    ch_idx_t idx_reg, idx_next;
    mask_t   mask_reg, mask_next;
    status_t status_reg, status_next;
    logic    armed_reg [CHANNELS];
    count_t  count_reg [CHANNELS];

    logic    accept;
    logic    ch_ok;
    ch_idx_t ch_sel;
    ch_idx_t rd_idx;
    count_t  cur_count;
    logic    cur_armed;
    count_t  unit_count;
    logic    unit_expired;
    logic    count_wr;
    count_t  count_wr_val;
    logic    armed_wr;
    logic    armed_wr_val;

    wdg_tick_unit u_unit (
        .count_in  (cur_count),
        .timeout   (timeout),
        .count_out (unit_count),
        .expired   (unit_expired)
    );

    assign accept    = in_valid && in_ready;
    assign ch_ok     = {1'b0, ch} < (CH_FIELD_W + 1)'(CHANNELS);
    assign ch_sel    = CH_IDX_W'(ch);
    assign rd_idx    = (state_reg == S_SCAN) ? idx_reg : ch_sel;
    assign cur_count = count_reg[rd_idx];
    assign cur_armed = armed_reg[rd_idx];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            for (int i = 0; i < CHANNELS; i++) begin
                armed_reg[i] <= 1'b0;
                count_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (count_wr) begin
                count_reg[rd_idx] <= count_wr_val;
            end
            if (armed_wr) begin
                armed_reg[rd_idx] <= armed_wr_val;
            end
        end
        idx_reg    <= idx_next;
        mask_reg   <= mask_next;
        status_reg <= status_next;
    end

    always_comb begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        mask_next    = mask_reg;
        status_next  = status_reg;
        count_wr     = 1'b0;
        count_wr_val = '0;
        armed_wr     = 1'b0;
        armed_wr_val = 1'b0;
        in_ready     = 1'b0;
        res_valid    = 1'b0;

        case (state_reg)
            S_IDLE: begin
                in_ready = 1'b1;
                if (accept) begin
                    mask_next   = '0;
                    status_next = ST_OK;
                    idx_next    = '0;
                    if (op == OP_TICK) begin
                        state_next = S_SCAN;
                    end else begin
                        state_next = S_DONE;
                        if (!ch_ok) begin
                            status_next = ST_BAD_CHANNEL;
                        end else begin
                            case (op)
                                OP_ENABLE: begin
                                    count_wr     = 1'b1;
                                    armed_wr     = 1'b1;
                                    armed_wr_val = 1'b1;
                                end
                                OP_DISABLE: begin
                                    armed_wr = 1'b1;
                                end
                                OP_KEEPALIVE: begin
                                    if (cur_armed) begin
                                        count_wr = 1'b1;
                                    end else begin
                                        status_next = ST_NOT_STARTED;
                                    end
                                end
                                default: begin
                                    status_next = ST_OK;
                                end
                            endcase
                        end
                    end
                end
            end
            S_SCAN: begin
                if (cur_armed) begin
                    count_wr     = 1'b1;
                    count_wr_val = unit_count;
                    // only channels below MASK_W have a mask bit
                    if (unit_expired && (32'(idx_reg) < MASK_W)) begin
                        mask_next = mask_reg | (MASK_W'(1) << idx_reg);
                    end
                end
                if (idx_reg == LAST_IDX) begin
                    state_next = S_DONE;
                end else begin
                    idx_next = idx_reg + CH_IDX_W'(1);
                end
            end
            S_DONE: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign result.status       = status_reg;
    assign result.expired_mask = mask_reg;

endmodule

// ===== rtl/multi_channel_watchdog.sv =====
// ----------------------------------------------------------------------------
// multi_channel_watchdog: multi-channel software watchdog timer
//
//  channel  dir  handshake          payload
//  s_       in   s_tvalid/s_tready  s_tdata: channel; s_tuser: operation
//  m_       out  m_tvalid/m_tready  m_tdata: status, expired_mask, any_expired
//  cfg_     in   cfg_wr_en          cfg_wr_data: timeout_seconds
//
// Enable, disable and keepalive go from transfer to result through the state
// register and then the output register. On a tick the single tick unit visits
// one channel counter per cycle. A finished result sits in the output register,
// so the next item is taken while it waits; only a second result stalls.
// Reset (aresetn low, synchronous) disarms all channels, clears the counters
// and loads timeout_seconds with 60.
// ----------------------------------------------------------------------------
module multi_channel_watchdog (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,     // [3:0] channel
    input  logic [1:0]  s_tuser,     // [1:0] operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,     // [1:0] status, [9:2] expired_mask, [10] any_expired
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data  // timeout_seconds
);
    import wdg_pkg::*;

    timeout_t timeout_reg;
    logic     out_valid_reg;
    result_t  out_res_reg;
    logic     res_valid;
    logic     res_ready;
    result_t  result;
    logic     any_expired;

    wdg_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .op        (op_t'(s_tuser)),
        .ch        (s_tdata[3:0]),
        .timeout   (timeout_reg),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .result    (result)
    );

    assign res_ready = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg   <= TIMEOUT_RESET;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                timeout_reg <= cfg_wr_data;
            end
            if (res_ready) begin
                out_valid_reg <= res_valid;
            end
        end
        if (res_valid && res_ready) begin
            out_res_reg <= result;
        end
    end

    assign any_expired = |out_res_reg.expired_mask;
    assign m_tvalid    = out_valid_reg;
    assign m_tdata     = {5'b0, any_expired, out_res_reg.expired_mask, out_res_reg.status};

endmodule

// ===== rtl/wdg_checker.sv =====
// ----------------------------------------------------------------------------
// wdg_checker: port-level checks for the multi-channel watchdog
// Watches the result channel and is bound to the top level.
// ----------------------------------------------------------------------------
module wdg_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);
    import wdg_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_any_matches_mask: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[10] == (m_tdata[9:2] != 8'd0)))
        else $error("any_expired does not follow expired_mask");

    // only a tick reports expirations, and a tick is always ok
    a_mask_only_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[1:0] != ST_OK) |-> (m_tdata[9:2] == 8'd0))
        else $error("expired_mask set on a non-ok result");

    a_padding_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[15:11] == 5'd0) && (m_tdata[1:0] != 2'd3))
        else $error("bad status code or padding");

endmodule

bind multi_channel_watchdog wdg_checker u_wdg_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== bench/multi_channel_watchdog_tb.sv =====
// ----------------------------------------------------------------------------
// multi_channel_watchdog_tb: self-checking bench for the multi-channel watchdog
// Drives tick, enable, disable and keepalive operations into the input stream.
// A scoreboard keeps its own copy of the arm bits, the seconds counters and
// the timeout. It predicts status and expired mask for every accepted
// transfer and compares each result transfer against the oldest prediction.
// The run goes through several timeout settings and source/sink throttling
// patterns, including a long sink hold-off and a full drain in mid-stream.
// ----------------------------------------------------------------------------
module multi_channel_watchdog_tb;
    import wdg_pkg::*;

    typedef struct packed {
        status_t status;
        mask_t   mask;
        logic    any_hit;
    } wdg_outcome_t;

    class wdg_scoreboard;
        logic [CHANNELS-1:0]                  armed;
        logic [CHANNELS-1:0][COUNT_WIDTH-1:0] since_feed;
        timeout_t                             timeout;
        wdg_outcome_t                         pending[$];
        int                                   errors;

        function new();
            armed      = '0;
            since_feed = '0;
            timeout    = TIMEOUT_RESET;
            errors     = 0;
        endfunction

        // Update the channel state for one accepted transfer and queue its result.
        function void note_op(op_t op, logic [3:0] ch);
            wdg_outcome_t r;
            r = '0;
            if (op == OP_TICK) begin
                for (int i = 0; i < CHANNELS; i++) begin
                    if (armed[i]) begin
                        if (since_feed[i] != {COUNT_WIDTH{1'b1}})
                            since_feed[i] = since_feed[i] + 1'b1;
                        if (since_feed[i] > timeout && i < MASK_W)
                            r.mask[i] = 1'b1;
                    end
                end
            end else if (ch >= CHANNELS) begin
                r.status = ST_BAD_CHANNEL;
            end else if (op == OP_ENABLE) begin
                since_feed[ch] = '0;
                armed[ch]      = 1'b1;
            end else if (op == OP_DISABLE) begin
                armed[ch] = 1'b0;
            end else if (armed[ch]) begin
                since_feed[ch] = '0;
            end else begin
                r.status = ST_NOT_STARTED;
            end
            r.any_hit = |r.mask;
            pending.push_back(r);
        endfunction

        task report_mismatch(string msg);
            $display("MISMATCH: %s", msg);
            errors++;
        endtask

        task check_result(logic [15:0] data);
            wdg_outcome_t want;
            if (pending.size() == 0) begin
                report_mismatch($sformatf("result %h with nothing outstanding", data));
                return;
            end
            want = pending.pop_front();
            if (data[1:0] !== want.status)
                report_mismatch($sformatf("status %0d, want %0d", data[1:0], want.status));
            if (data[9:2] !== want.mask)
                report_mismatch($sformatf("expired_mask %h, want %h", data[9:2], want.mask));
            if (data[10] !== want.any_hit)
                report_mismatch($sformatf("any_expired %b, want %b", data[10], want.any_hit));
        endtask
    endclass

    localparam int RUN_LIMIT     = 300000;
    localparam int SETTLE_CYCLES = CHANNELS + 4;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata     = '0;
    logic [1:0]  s_tuser     = '0;
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [15:0] m_tdata;
    logic        cfg_wr_en   = 1'b0;
    logic [15:0] cfg_wr_data = '0;

    int gap_pct         = 0;
    int stall_pct       = 0;
    int hold_off_cycles = 0;
    int cycle_count     = 0;

    wdg_scoreboard sb = new();

    multi_channel_watchdog u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT) begin
            $display("multi_channel_watchdog_tb: done, errors");
            $finish;
        end
    end

    // Result side: check every transfer, then pick tready for the next edge.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata);
        if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99, 0) >= stall_pct);
        end
    end

    task automatic send_op(op_t op, logic [3:0] ch);
        while (gap_pct != 0 && $urandom_range(99, 0) < gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {4'b0, ch};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        sb.note_op(op, ch);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge aclk);
    endtask

    task automatic settle();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_timeout(timeout_t value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        sb.timeout  = value;
    endtask

    // Ticks are the most frequent op so counters climb; a few non-tick ops hit bad channels.
    task automatic run_random(int n_items, int gap, int stall);
        op_t        op;
        logic [3:0] ch;
        int         roll;
        gap_pct   = gap;
        stall_pct = stall;
        for (int k = 0; k < n_items; k++) begin
            roll = $urandom_range(99, 0);
            if (roll < 40)
                op = OP_TICK;
            else if (roll < 55)
                op = OP_ENABLE;
            else if (roll < 65)
                op = OP_DISABLE;
            else
                op = OP_KEEPALIVE;
            if (op == OP_TICK || $urandom_range(9, 0) == 0)
                ch = 4'($urandom_range(15, 0));
            else
                ch = 4'($urandom_range(CHANNELS - 1, 0));
            send_op(op, ch);
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: reset timeout, nothing armed, bad channels
        send_op(OP_TICK, 4'd15);
        send_op(OP_KEEPALIVE, 4'd0);
        send_op(OP_ENABLE, 4'd0);
        send_op(OP_ENABLE, 4'd7);
        send_op(OP_ENABLE, 4'd8);
        send_op(OP_DISABLE, 4'd15);
        send_op(OP_KEEPALIVE, 4'd12);
        send_op(OP_TICK, 4'd0);
        settle();
        write_timeout(16'd0);
        send_op(OP_TICK, 4'd9);
        settle();
        write_timeout(16'd1);
        send_op(OP_KEEPALIVE, 4'd0);
        send_op(OP_TICK, 4'd0);
        send_op(OP_DISABLE, 4'd7);
        send_op(OP_TICK, 4'd0);
        send_op(OP_KEEPALIVE, 4'd7);    // disarmed channel
        for (int c = 1; c < CHANNELS - 1; c++)
            send_op(OP_ENABLE, 4'(c));
        send_op(OP_TICK, 4'd0);
        send_op(OP_TICK, 4'd0);
        settle();
        write_timeout(16'hFFFF);
        send_op(OP_TICK, 4'd0);
        settle();

        // no throttling; long sink hold-off, then a full drain mid-stream
        write_timeout(16'd3);
        run_random(80, 0, 0);
        hold_off_cycles = 300;
        run_random(100, 0, 0);
        wait_drained();
        run_random(80, 0, 0);
        settle();

        write_timeout(16'd0);
        run_random(240, 46, 0);
        settle();

        write_timeout(timeout_t'($urandom_range(8, 1)));
        run_random(240, 0, 46);
        settle();

        write_timeout(16'd5);
        run_random(260, 19, 19);
        settle();

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("multi_channel_watchdog_tb: done, clean");
        else
            $display("multi_channel_watchdog_tb: done, errors");
        $finish;
    end

endmodule
